// ===== rtl/modrtu_pkg.sv =====
// Shared types, codes and the CRC byte update for the Modbus RTU frame checker.
package modrtu_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam int          MIN_FRAME_BYTES = 3;
    localparam logic [7:0]  BROADCAST_ADDR  = 8'h00;
    localparam logic [7:0]  STATION_RESET   = 8'h01;
    localparam logic [7:0]  PDU_MAX         = 8'hFF;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_BROADCAST = 3'd1,
        ST_FOREIGN   = 3'd2,
        ST_SIZE      = 3'd3,
        ST_CRC       = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] pdu_length;
    } result_t;

    // Fold one byte into the reflected CRC-16, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_frame_checker.sv =====
// The verdict is formed from the frame's last word and registered in the output or skid register.
// Throughput: one byte per cycle; the byte-wide CRC update and checks fit between the
// frame state registers and the two-entry result buffer.
// Words are refused only while both result entries are full.
// Reset: CRC reloads to 0xFFFF, count and address byte clear, station address reads 1.
module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: station address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pdu_length
    output logic [2:0]  m_axis_tuser    // [2:0] frame_status
);
    import modrtu_pkg::*;

    logic    [7:0] station_reg;
    logic          in_accept;
    logic          res_valid;
    result_t       res;
    result_t       out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_axis_tvalid & s_axis_tready;

    // Hold the own station address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            station_reg <= STATION_RESET;
        else if (cfg_valid)
            station_reg <= cfg_data;
    end

    modrtu_frame_acc #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_acc (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_accept),
        .data_byte       (s_axis_tdata),
        .last_byte       (s_axis_tlast),
        .station_address (station_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    modrtu_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = out_res.pdu_length;
    assign m_axis_tuser = out_res.status;

endmodule

// ===== rtl/modrtu_frame_acc.sv =====
// Per-frame state (CRC, byte count, address byte) and the end-of-frame verdict.
module modrtu_frame_acc #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [7:0]         station_address,
    output logic               res_valid,
    output modrtu_pkg::result_t res
);
    import modrtu_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int PDU_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

    logic [15:0]      crc_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       first_reg;

    logic [15:0]      crc_next;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       first_next;
    logic [PDU_W-1:0] pdu_full;
    logic [7:0]       pdu_sat;

    // Advance the running values with the incoming word
    always_comb
    begin
        crc_next   = crc_byte(crc_reg, data_byte);
        first_next = (count_reg == '0) ? data_byte : first_reg;
        count_next = (count_reg <= CNT_MAX) ? count_reg + 1'b1 : count_reg;
    end

    // Clamp the PDU length to the field width
    always_comb
    begin
        pdu_full = PDU_W'(count_next) - PDU_W'(CNT_MIN);
        if (pdu_full > PDU_W'(PDU_MAX))
            pdu_sat = PDU_MAX;
        else
            pdu_sat = pdu_full[7:0];
    end

    // Check size, then address, then CRC residue
    always_comb
    begin
        res.pdu_length = 8'h00;
        if (count_next < CNT_MIN || count_next > CNT_MAX) begin
            res.status = ST_SIZE;
        end
        else if (first_next != station_address && first_next != BROADCAST_ADDR) begin
            res.status = ST_FOREIGN;
        end
        else if (crc_next != 16'h0000) begin
            res.status = ST_CRC;
        end
        else begin
            res.status     = (first_next == station_address) ? ST_NORMAL : ST_BROADCAST;
            res.pdu_length = pdu_sat;
        end
    end

    assign res_valid = in_valid & last_byte;

    // Hold state between words, reload CRC and count at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            first_reg <= 8'h00;
        end
        else if (in_valid) begin
            first_reg <= first_next;
            if (last_byte) begin
                crc_reg   <= CRC_INIT;
                count_reg <= '0;
            end
            else begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ===== rtl/modrtu_out_skid.sv =====
// Two-entry result buffer: output register plus skid register.
module modrtu_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  modrtu_pkg::result_t push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output modrtu_pkg::result_t out_data
);
    import modrtu_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Drain the skid entry into the output register first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else begin
                main_valid_reg <= push;
            end
        end
        else if (push) begin
            if (!main_valid_reg)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge clk)
    begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push)
                    skid_reg <= push_data;
            end
            else if (push) begin
                main_reg <= push_data;
            end
        end
        else if (push) begin
            if (!main_valid_reg)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule
